@@ rtl/hsv_hue_range_shift_assert.svh @@
// Assertion macros for the hue shift RTL.
`ifndef HSV_HUE_RANGE_SHIFT_ASSERT_SVH
`define HSV_HUE_RANGE_SHIFT_ASSERT_SVH
`ifndef SYNTHESIS
`define HSV_ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("hsv_hue_range_shift: check failed");
`define HSV_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("hsv_hue_range_shift: check failed");
`else
`define HSV_ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons)
`define HSV_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons)
`endif
`endif

@@ rtl/hsv_pkg.sv @@
// Shared constants and types for the hue range shift pipeline.
package hsv_pkg;

  localparam int DEND_W = 25;
  localparam int DSR_W  = 9;
  localparam int QUO_W  = 17;

  localparam int LATENCY = 27;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [1:0] REG_HUE_LOW   = 2'd0;
  localparam logic [1:0] REG_HUE_HIGH  = 2'd1;
  localparam logic [1:0] REG_HUE_SHIFT = 2'd2;

  localparam logic [16:0] SECTOR_Q8 = 17'd15360;
  localparam logic [16:0] HUE_FULL  = 17'd92160;
  localparam logic [29:0] SCALE_FULL = 30'd1006632960;
  localparam logic [38:0] SCALE_HALF = 39'd503316480;
  localparam logic [12:0] RECIP_15  = 13'd4370;

  typedef struct packed {
    logic       valid;
    logic       pass;
    logic       grey;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] mx;
    logic [1:0] sel;
  } side_t;

endpackage

@@ rtl/hsv_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module hsv_div
  import hsv_pkg::*;
(
  input  logic              clk,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DSR_W-1:0]  divisor,
  output logic [QUO_W-1:0]  quotient
);

  logic [DSR_W-1:0] rem_s [1:QUO_W];
  logic [QUO_W-1:0] low_s [1:QUO_W];
  logic [DSR_W-1:0] dsr_s [1:QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic [QUO_W-1:0] low_in;
    logic [DSR_W-1:0] dsr_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign trial  = {1'b0, dividend[DEND_W-1:QUO_W], dividend[QUO_W-1]};
      assign low_in = dividend[QUO_W-1:0];
      assign dsr_in = divisor;
    end else begin : g_next
      assign trial  = {rem_s[i], low_s[i][QUO_W-1]};
      assign low_in = low_s[i];
      assign dsr_in = dsr_s[i];
    end

    assign diff = trial - {1'b0, dsr_in};
    assign ge   = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      rem_s[i+1] <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      low_s[i+1] <= {low_in[QUO_W-2:0], ge};
      dsr_s[i+1] <= dsr_in;
    end
  end

  assign quotient = low_s[QUO_W];

endmodule

@@ rtl/hsv_hue_range_shift.sv @@
// Top level of the RGBA hue range shift pipeline.
//
// One pixel enters as a transaction when start is high and busy is low; busy
// is high only while rst is held, so a pixel may be offered on every clock.
// Each result leaves as one transaction: done is high for exactly one cycle
// with red_out, green_out, blue_out and alpha_out valid in that cycle. The
// receiver cannot stall, so results are never held back.
// A pixel accepted at a clock edge passes through stage 1, the two 17-stage
// restoring dividers (hue fraction and saturation) that run side by side
// and nine stages for hue assembly, band shift, hue wrap, sector split and
// the back conversion before its result reaches the ports. Throughput is one
// pixel per clock while rst is low.
// The user must write configuration through wr_en, wr_index and wr_data only
// while the pipeline is empty; the block does not enforce this. The three
// registers feed the stages after the dividers. Synchronous reset clears the
// valid bits of every stage and the registers; pixels in flight are dropped.
module hsv_hue_range_shift
  import hsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [9:0] wr_data,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  output logic       done,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out
);

  `include "hsv_hue_range_shift_assert.svh"

  // Configuration registers.
  logic [8:0]        hue_low;
  logic [8:0]        hue_high;
  logic signed [9:0] hue_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low   <= '0;
      hue_high  <= '0;
      hue_shift <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HUE_LOW:   hue_low   <= wr_data[8:0];
        REG_HUE_HIGH:  hue_high  <= wr_data[8:0];
        REG_HUE_SHIFT: hue_shift <= $signed(wr_data);
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // Stage 1: max, min, delta and the numerator term of the hue fraction.
  logic [7:0] mx_c, mn_c, delta_c;
  logic [1:0] sel_c;
  logic [8:0] x_c;
  side_t      s1;
  logic [7:0] delta1;
  logic [8:0] x1;

  always_comb begin
    if (red_in >= green_in && red_in >= blue_in) begin
      mx_c  = red_in;
      sel_c = SEL_RED;
    end else if (green_in >= blue_in) begin
      mx_c  = green_in;
      sel_c = SEL_GREEN;
    end else begin
      mx_c  = blue_in;
      sel_c = SEL_BLUE;
    end
    mn_c = (red_in < green_in) ? red_in : green_in;
    if (blue_in < mn_c) mn_c = blue_in;
    delta_c = mx_c - mn_c;
    // n + delta, always in 0 .. 2*delta.
    case (sel_c)
      SEL_RED:   x_c = {1'b0, green_in} + {1'b0, delta_c} - {1'b0, blue_in};
      SEL_GREEN: x_c = {1'b0, blue_in} + {1'b0, delta_c} - {1'b0, red_in};
      default:   x_c = {1'b0, red_in} + {1'b0, delta_c} - {1'b0, green_in};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1.valid <= start && !busy;
      s1.pass  <= (alpha_in == 8'd0);
      s1.grey  <= (delta_c == 8'd0);
      s1.r     <= red_in;
      s1.g     <= green_in;
      s1.b     <= blue_in;
      s1.mx    <= mx_c;
      s1.sel   <= sel_c;
    end
    delta1 <= delta_c;
    x1     <= x_c;
  end

  // Two dividers: hue fraction round(15360*x/delta) and saturation
  // round(65536*delta/mx), both as floor((2*num + den) / (2*den)).
  logic [DEND_W-1:0] hue_dend, sat_dend;
  logic [QUO_W-1:0]  hue_quo, sat_quo;

  assign hue_dend = DEND_W'(x1) * DEND_W'(30720) + DEND_W'(delta1);
  assign sat_dend = {delta1, 17'd0} + DEND_W'(s1.mx);

  hsv_div u_hue_div (
    .clk      (clk),
    .dividend (hue_dend),
    .divisor  ({delta1, 1'b0}),
    .quotient (hue_quo)
  );

  hsv_div u_sat_div (
    .clk      (clk),
    .dividend (sat_dend),
    .divisor  ({s1.mx, 1'b0}),
    .quotient (sat_quo)
  );

  // Side information travels alongside the dividers.
  side_t sb [1:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= QUO_W; k++) sb[k] <= '0;
    end else begin
      sb[1] <= s1;
      for (int k = 2; k <= QUO_W; k++) sb[k] <= sb[k-1];
    end
  end

  // Stage A: hue from the fraction and the sector base of the max channel.
  logic signed [18:0] hraw;
  side_t              sa;
  logic [16:0]        h_a, s_a;

  always_comb begin
    case (sb[QUO_W].sel)
      SEL_RED:   hraw = $signed({2'b0, hue_quo}) - 19'sd15360;
      SEL_GREEN: hraw = $signed({2'b0, hue_quo}) + 19'sd15360;
      default:   hraw = $signed({2'b0, hue_quo}) + 19'sd46080;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) sa <= '0;
    else     sa <= sb[QUO_W];
    h_a <= hraw[18] ? 17'(hraw + 19'sd92160) : hraw[16:0];
    s_a <= sat_quo;
  end

  // Stage B: band test against the whole-degree bounds, then the shift.
  logic               inband;
  logic signed [18:0] hs_c;
  side_t              sbb;
  logic signed [18:0] hs_b;
  logic [16:0]        s_b;

  assign inband = (h_a >= {hue_low, 8'd0}) && (h_a <= {hue_high, 8'd0});
  assign hs_c = $signed({2'b0, h_a}) + ($signed({{9{hue_shift[9]}}, hue_shift}) <<< 8);

  always_ff @(posedge clk) begin
    if (rst) sbb <= '0;
    else     sbb <= sa;
    hs_b <= inband ? hs_c : $signed({2'b0, h_a});
    s_b  <= s_a;
  end

  // Stage C: wrap back into 0..360 degrees.
  logic [18:0] mag;
  logic [9:0]  deg_p, deg_p1, deg_p2;
  logic [10:0] deg_n, deg_n1;
  logic [16:0] hw_c;
  side_t       sc;
  logic [16:0] h_c, s_c;

  always_comb begin
    mag    = 19'(-hs_b);
    deg_p  = hs_b[17:8];
    deg_p1 = (deg_p >= 10'd360) ? deg_p - 10'd360 : deg_p;
    deg_p2 = (deg_p1 >= 10'd360) ? deg_p1 - 10'd360 : deg_p1;
    deg_n  = mag[18:8];
    deg_n1 = (deg_n >= 11'd360) ? deg_n - 11'd360 : deg_n;
    if (hs_b[18]) begin
      if (deg_n1 == 11'd0) hw_c = '0;
      else hw_c = {9'(11'd360 - deg_n1), 8'd0};
    end else if (hs_b[16:0] < HUE_FULL && !hs_b[17]) begin
      hw_c = hs_b[16:0];
    end else begin
      hw_c = {deg_p2[8:0], 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sc <= '0;
    else     sc <= sbb;
    h_c <= hw_c;
    s_c <= s_b;
  end

  // Stage D: sector and offset inside the sector.
  logic [2:0]  sector_c;
  logic [16:0] base_c;
  side_t       sd;
  logic [2:0]  sector_d;
  logic [13:0] fn_d;
  logic [16:0] s_d;

  always_comb begin
    if      (h_c >= 17'd76800) begin sector_c = 3'd5; base_c = 17'd76800; end
    else if (h_c >= 17'd61440) begin sector_c = 3'd4; base_c = 17'd61440; end
    else if (h_c >= 17'd46080) begin sector_c = 3'd3; base_c = 17'd46080; end
    else if (h_c >= 17'd30720) begin sector_c = 3'd2; base_c = 17'd30720; end
    else if (h_c >= SECTOR_Q8) begin sector_c = 3'd1; base_c = SECTOR_Q8; end
    else                       begin sector_c = 3'd0; base_c = '0;        end
  end

  always_ff @(posedge clk) begin
    if (rst) sd <= '0;
    else     sd <= sc;
    sector_d <= sector_c;
    fn_d     <= 14'(h_c - base_c);
    s_d      <= s_c;
  end

  // Stage E: products with the saturation.
  side_t       se;
  logic [2:0]  sector_e;
  logic [30:0] sfn_e;
  logic [30:0] s15_e;
  logic [24:0] pm_e;

  always_ff @(posedge clk) begin
    if (rst) se <= '0;
    else     se <= sd;
    sector_e <= sector_d;
    sfn_e    <= 31'(s_d) * 31'(fn_d);
    s15_e    <= (31'(s_d) << 14) - (31'(s_d) << 10);
    pm_e     <= 25'(sd.mx) * (25'(17'h10000) - 25'(s_d));
  end

  // Stage F: scale factors for q and t, rounded p.
  side_t       sf;
  logic [2:0]  sector_f;
  logic [29:0] aq_f, at_f;
  logic [7:0]  p_f;
  logic [24:0] pr_c;

  assign pr_c = pm_e + 25'd32768;

  always_ff @(posedge clk) begin
    if (rst) sf <= '0;
    else     sf <= se;
    sector_f <= sector_e;
    aq_f     <= 30'(31'(SCALE_FULL) - sfn_e);
    at_f     <= 30'(31'(SCALE_FULL) - s15_e + sfn_e);
    p_f      <= pr_c[23:16];
  end

  // Stage G: value times the scale factors, plus half for rounding.
  side_t       sg;
  logic [2:0]  sector_g;
  logic [7:0]  p_g;
  logic [38:0] mq_g, mt_g;

  always_ff @(posedge clk) begin
    if (rst) sg <= '0;
    else     sg <= sf;
    sector_g <= sector_f;
    p_g      <= p_f;
    mq_g     <= 39'(sf.mx) * 39'(aq_f) + SCALE_HALF;
    mt_g     <= 39'(sf.mx) * 39'(at_f) + SCALE_HALF;
  end

  // Stage H: the 2^26 part of the divisor is a shift, the factor of 15 a
  // reciprocal multiply that is exact for these magnitudes.
  side_t       sh;
  logic [2:0]  sector_h;
  logic [7:0]  p_h;
  logic [25:0] zq_h, zt_h;

  always_ff @(posedge clk) begin
    if (rst) sh <= '0;
    else     sh <= sg;
    sector_h <= sector_g;
    p_h      <= p_g;
    zq_h     <= 26'(mq_g[38:26]) * 26'(RECIP_15);
    zt_h     <= 26'(mt_g[38:26]) * 26'(RECIP_15);
  end

  // Stage I: pick the channels and register the result.
  logic [7:0] q_c, t_c, ro_c, go_c, bo_c;

  always_comb begin
    q_c = zq_h[23:16];
    t_c = zt_h[23:16];
    case (sector_h)
      3'd0:    begin ro_c = sh.mx; go_c = t_c;   bo_c = p_h;   end
      3'd1:    begin ro_c = q_c;   go_c = sh.mx; bo_c = p_h;   end
      3'd2:    begin ro_c = p_h;   go_c = sh.mx; bo_c = t_c;   end
      3'd3:    begin ro_c = p_h;   go_c = q_c;   bo_c = sh.mx; end
      3'd4:    begin ro_c = t_c;   go_c = p_h;   bo_c = sh.mx; end
      default: begin ro_c = sh.mx; go_c = p_h;   bo_c = q_c;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sh.valid;
    end
    if (sh.pass) begin
      red_out   <= sh.r;
      green_out <= sh.g;
      blue_out  <= sh.b;
      alpha_out <= 8'd0;
    end else if (sh.grey) begin
      red_out   <= sh.mx;
      green_out <= sh.mx;
      blue_out  <= sh.mx;
      alpha_out <= 8'd255;
    end else begin
      red_out   <= ro_c;
      green_out <= go_c;
      blue_out  <= bo_c;
      alpha_out <= 8'd255;
    end
  end

  // A result only ever follows an accepted pixel by the fixed latency.
  `HSV_ASSERT_IMPLY(a_done_follows_start, clk, rst, done, $past(start && !busy, LATENCY))
  // Alpha leaves as either zero or full.
  `HSV_ASSERT_IMPLY(a_alpha_code, clk, rst, done, alpha_out == 8'd0 || alpha_out == 8'd255)
  // A transparent pixel keeps its colour channels; red and blue are checked.
  `HSV_ASSERT_IMPLY(a_pass_through, clk, rst, done && alpha_out == 8'd0,
                    red_out == $past(red_in, LATENCY) && blue_out == $past(blue_in, LATENCY))
  // The stage after the dividers carries the pixel in the next cycle.
  `HSV_ASSERT_NEXT(a_stage_a, clk, rst, sb[QUO_W].valid, sa.valid)

endmodule

@@ tb/hsv_hue_range_shift_tb.sv @@
// Self-checking testbench for the RGBA hue range shift pipeline.
`timescale 1ns / 1ps

module hsv_hue_range_shift_tb
  import hsv_pkg::*;
();

  // A single pixel: either the one offered to the block or the one it returns.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  // One row of the directed table. When has_known is set, the expected pixel
  // is typed in by hand and is also compared with the predictor's output.
  typedef struct {
    pixel_t pix;
    bit     has_known;
    pixel_t known;
  } vec_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       wr_en;
  logic [1:0] wr_index;
  logic [9:0] wr_data;
  logic [7:0] red_in, green_in, blue_in, alpha_in;
  logic       done;
  logic [7:0] red_out, green_out, blue_out, alpha_out;

  // Configuration copy used by the predictor.
  logic [8:0]        band_lo;
  logic [8:0]        band_hi;
  logic signed [9:0] band_shift;

  pixel_t shifted_pixels[$];
  int     error_count;

  hsv_hue_range_shift dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .done(done), .red_out(red_out), .green_out(green_out),
    .blue_out(blue_out), .alpha_out(alpha_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous limit: roughly a thousand pixels with long gaps and drains fit
  // well inside this by a wide margin.
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // round(v * (1 - s*num/den)) with s carrying 16 fraction bits.
  function automatic logic [7:0] scale_value(input logic [7:0] v, input longint s,
                                             input longint num, input longint den);
    longint whole, prod;
    whole = 65536 * den;
    prod  = longint'(v) * (whole - s * num);
    return 8'((prod + whole / 2) / whole);
  endfunction

  // Folds a shifted hue back into the circle, losing the fraction if it left.
  function automatic int fold_hue(input int h);
    int deg;
    if (h >= 0 && h < 92160) return h;
    if (h >= 92160) return ((h >>> 8) % 360) * 256;
    deg = ((-h) >>> 8) % 360;
    if (deg == 0) return 0;
    return (360 - deg) * 256;
  endfunction

  // Works out the pixel the block should return for a given input pixel.
  function automatic pixel_t shift_hue(input pixel_t px);
    pixel_t res;
    int mx, mn, delta, n, part, h, s, sector, fn;
    logic [1:0] sel;
    logic [7:0] p, q, t, v;
    if (px.a == 8'd0) begin
      res = px;
      return res;
    end
    if (px.r >= px.g && px.r >= px.b) begin
      mx = px.r; sel = SEL_RED; n = int'(px.g) - int'(px.b);
    end else if (px.g >= px.b) begin
      mx = px.g; sel = SEL_GREEN; n = int'(px.b) - int'(px.r);
    end else begin
      mx = px.b; sel = SEL_BLUE; n = int'(px.r) - int'(px.g);
    end
    mn = px.r;
    if (px.g < mn) mn = px.g;
    if (px.b < mn) mn = px.b;
    delta = mx - mn;
    v = 8'(mx);
    if (delta == 0) begin
      res = '{v, v, v, 8'd255};
      return res;
    end
    part = (2 * 15360 * (n + delta) + delta) / (2 * delta);
    h = (int'(sel) * 120 - 60) * 256 + part;
    if (h < 0) h += 92160;
    s = (delta * 2 * 65536 + mx) / (2 * mx);
    if (h >= int'(band_lo) * 256 && h <= int'(band_hi) * 256)
      h = fold_hue(h + int'(band_shift) * 256);
    sector = h / 15360;
    fn = h % 15360;
    p = scale_value(v, s, 1, 1);
    q = scale_value(v, s, fn, 15360);
    t = scale_value(v, s, 15360 - fn, 15360);
    case (sector)
      0:       res = '{v, t, p, 8'd255};
      1:       res = '{q, v, p, 8'd255};
      2:       res = '{p, v, t, 8'd255};
      3:       res = '{p, q, v, 8'd255};
      4:       res = '{t, p, v, 8'd255};
      default: res = '{v, p, q, 8'd255};
    endcase
    return res;
  endfunction

  // Results arrive one cycle at a time and are checked against the oldest
  // expectation in arrival order.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (shifted_pixels.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = shifted_pixels.pop_front();
        if (red_out !== want.r)
          report_mismatch($sformatf("red %0d, expected %0d", red_out, want.r));
        if (green_out !== want.g)
          report_mismatch($sformatf("green %0d, expected %0d", green_out, want.g));
        if (blue_out !== want.b)
          report_mismatch($sformatf("blue %0d, expected %0d", blue_out, want.b));
        if (alpha_out !== want.a)
          report_mismatch($sformatf("alpha %0d, expected %0d", alpha_out, want.a));
      end
    end
  end

  // Mostly short pauses, now and then a long one, sometimes none at all.
  // start is lowered only when the pause is not empty.
  task automatic idle_gap();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) len = 0;
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Offers one pixel and holds start until the block takes the transaction.
  // start is lowered only if the next pixel does not follow straight on.
  task automatic send_pixel(input pixel_t px);
    shifted_pixels.push_back(shift_hue(px));
    red_in   <= px.r;
    green_in <= px.g;
    blue_in  <= px.b;
    alpha_in <= px.a;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Lowers start and waits for the pipeline to empty.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (shifted_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Registers are only written while the pipeline is empty.
  task automatic write_band(input logic [8:0] lo, input logic [8:0] hi,
                            input logic signed [9:0] sh);
    wr_en <= 1'b1;
    wr_index <= REG_HUE_LOW;   wr_data <= {1'b0, lo};
    @(posedge clk);
    wr_index <= REG_HUE_HIGH;  wr_data <= {1'b0, hi};
    @(posedge clk);
    wr_index <= REG_HUE_SHIFT; wr_data <= sh;
    @(posedge clk);
    wr_en <= 1'b0;
    band_lo = lo;
    band_hi = hi;
    band_shift = sh;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = $urandom;
    case ($urandom_range(0, 9))
      0: px.a = 8'd0;                                   // pass through
      1: begin px.g = px.r; px.b = px.r; end            // grey
      2: px.b = px.g;                                   // ties between channels
      3: px.r = 8'd255;
      default: ;
    endcase
    if (px.a == 8'd0 && $urandom_range(0, 3) != 0) px.a = 8'd255;
    return px;
  endfunction

  initial begin
    vec_t table_rows[$];
    int k;
    error_count = 0;
    start = 1'b0; wr_en = 1'b0; wr_index = REG_HUE_LOW; wr_data = '0;
    red_in = '0; green_in = '0; blue_in = '0; alpha_in = '0;
    band_lo = '0; band_hi = '0; band_shift = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset configuration, where only a hue of
    // exactly zero lies in the band and the shift is zero.
    table_rows.push_back('{'{8'd10, 8'd20, 8'd30, 8'd0}, 1, '{8'd10, 8'd20, 8'd30, 8'd0}});
    table_rows.push_back('{'{8'd0, 8'd0, 8'd0, 8'd255}, 1, '{8'd0, 8'd0, 8'd0, 8'd255}});
    table_rows.push_back('{'{8'd255, 8'd255, 8'd255, 8'd1}, 1,
                           '{8'd255, 8'd255, 8'd255, 8'd255}});
    table_rows.push_back('{'{8'd255, 8'd0, 8'd0, 8'd255}, 1, '{8'd255, 8'd0, 8'd0, 8'd255}});
    table_rows.push_back('{'{8'd0, 8'd255, 8'd0, 8'd255}, 1, '{8'd0, 8'd255, 8'd0, 8'd255}});
    table_rows.push_back('{'{8'd0, 8'd0, 8'd255, 8'd255}, 1, '{8'd0, 8'd0, 8'd255, 8'd255}});
    table_rows.push_back('{'{8'd255, 8'd0, 8'd255, 8'd128}, 0, '0});
    table_rows.push_back('{'{8'd255, 8'd255, 8'd0, 8'd255}, 0, '0});
    table_rows.push_back('{'{8'd1, 8'd0, 8'd0, 8'd255}, 0, '0});
    table_rows.push_back('{'{8'd255, 8'd0, 8'd1, 8'd255}, 0, '0});
    table_rows.push_back('{'{8'd0, 8'd255, 8'd255, 8'd255}, 0, '0});
    table_rows.push_back('{'{8'd128, 8'd64, 8'd200, 8'd255}, 0, '0});
    foreach (table_rows[i]) begin
      if (table_rows[i].has_known && shift_hue(table_rows[i].pix) !== table_rows[i].known)
        report_mismatch($sformatf("predictor disagrees with table row %0d", i));
      send_pixel(table_rows[i].pix);
      if (i % 3 == 2) idle_gap();
    end
    drain();

    // Extreme band settings: a full wrap forward, a full wrap back, an empty
    // band, and register values above 360.
    write_band(9'd0, 9'd360, 10'sd360);
    for (k = 0; k < 6; k++) send_pixel(random_pixel());
    drain();
    write_band(9'd0, 9'd360, -10'sd360);
    for (k = 0; k < 6; k++) send_pixel(random_pixel());
    drain();
    write_band(9'd300, 9'd10, 10'sd90);
    for (k = 0; k < 4; k++) send_pixel(random_pixel());
    drain();
    write_band(9'd511, 9'd511, -10'sd512);
    for (k = 0; k < 3; k++) send_pixel('{8'd255, 8'd0, 8'd1, 8'd255});
    drain();

    // Random phases, each with its own band and shift.
    for (int phase = 0; phase < 8; phase++) begin
      write_band(9'($urandom_range(0, 360)), 9'($urandom_range(0, 360)),
                 10'($signed($urandom_range(0, 720)) - 360));
      if (phase == 7) write_band(9'($urandom), 9'($urandom), 10'($urandom));
      for (k = 0; k < 100; k++) begin
        send_pixel(random_pixel());
        if ($urandom_range(0, 4) == 0) idle_gap();
      end
      drain();
    end

    // Final wait for anything left, bounded by the limit block.
    while (shifted_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
